FILE: design/cht_pkg.sv
`timescale 1ns / 1ps

package cht_pkg;

	localparam int KEY_W = 32;
	localparam int CAP_W = 11;
	localparam int CNT_W = 12;
	localparam int CAP_RESET = 1024;

	typedef enum logic [1:0] {
		CMD_LOOKUP = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_DELETE = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIV1,
		ST_WAIT1,
		ST_DIV2,
		ST_WAIT2,
		ST_READ,
		ST_CHECK,
		ST_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic clear_step;
		logic load_key;
		logic div_start;
		logic div_second;
		logic latch_s1;
		logic latch_s2;
		logic rd_en;
		logic wr_kick;
		logic swap;
		logic del1;
		logic del2;
		logic cnt_inc;
		logic cnt_dec;
		logic res_load;
		logic res_ok;
		logic res_drop;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clear_last;
		logic div_done;
		logic hit1;
		logic hit2;
		logic sel_valid;
	} dp_stat_t;

endpackage

FILE: design/cht_divider.sv
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle
module cht_divider (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [cht_pkg::KEY_W-1:0] dividend,
	input  logic [cht_pkg::CAP_W-1:0] divisor,
	output logic                     done,
	output logic [cht_pkg::KEY_W-1:0] quot,
	output logic [cht_pkg::CAP_W-1:0] rem
);
	import cht_pkg::*;

	localparam int CW = $clog2(KEY_W + 1);

	logic [KEY_W-1:0] dvd_q;
	logic [CAP_W-1:0] rem_q;
	logic [CW-1:0]    cnt_q;
	logic             done_q;
	logic [CAP_W:0]   trial;
	logic             fits;

	assign trial = {rem_q, dvd_q[KEY_W-1]};
	assign fits  = trial >= {1'b0, divisor};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CW'(1));
			if (start) cnt_q <= CW'(KEY_W);
			else if (cnt_q != '0) cnt_q <= cnt_q - CW'(1);
		end
	end

	// shift and subtract
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			dvd_q <= {dvd_q[KEY_W-2:0], fits};
			rem_q <= fits ? CAP_W'(trial - {1'b0, divisor}) : trial[CAP_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = dvd_q;
	assign rem  = rem_q;

endmodule

FILE: design/cht_datapath.sv
`timescale 1ns / 1ps

module cht_datapath #(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cht_pkg::dp_cmd_t           cmd,
	output cht_pkg::dp_stat_t          stat,
	input  logic                       cfg_valid,
	input  logic [cht_pkg::CAP_W-1:0]  cfg_data,
	input  logic signed [cht_pkg::KEY_W-1:0] key,
	output logic                       success,
	output logic                       dropped_valid,
	output logic signed [cht_pkg::KEY_W-1:0] dropped_key,
	output logic [cht_pkg::CNT_W-1:0]  entry_count
);
	import cht_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);

	// word layout: valid bit over key
	logic [KEY_W:0] mem1 [TABLE_DEPTH];
	logic [KEY_W:0] mem2 [TABLE_DEPTH];

	logic [CAP_W-1:0] cap_q;
	logic [CAP_W-1:0] eff_cap;
	logic [AW-1:0]    clr_q;
	logic [KEY_W-1:0] cur_q;
	logic             which_q;
	logic [AW-1:0]    slot1_q, slot2_q;
	logic [KEY_W:0]   rd1_q, rd2_q;
	logic [CNT_W-1:0] cnt_q;
	logic             ok_q, drop_q;
	logic [KEY_W-1:0] dkey_q;

	logic [KEY_W-1:0] mag, dvd, quot, ev;
	logic [CAP_W-1:0] rem;
	logic             div_done;
	logic             we1, we2;
	logic [AW-1:0]    wa1, wa2;
	logic [KEY_W:0]   wd;

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cap_q <= CAP_W'(CAP_RESET);
		else if (cfg_valid) cap_q <= cfg_data;
	end

	always_comb begin
		if (cap_q == '0) eff_cap = CAP_W'(1);
		else if (32'(cap_q) > 32'(TABLE_DEPTH)) eff_cap = CAP_W'(TABLE_DEPTH);
		else eff_cap = cap_q;
	end

	// hashing: |cur| / cap, then quotient / cap
	assign mag = cur_q[KEY_W-1] ? (~cur_q + KEY_W'(1)) : cur_q;
	assign dvd = cmd.div_second ? quot : mag;

	cht_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dvd),
		.divisor  (eff_cap),
		.done     (div_done),
		.quot     (quot),
		.rem      (rem)
	);

	always_ff @(posedge clk) begin
		if (cmd.latch_s1) slot1_q <= AW'(rem);
		if (cmd.latch_s2) slot2_q <= AW'(rem);
	end

	// clearing pass counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_q <= '0;
		else if (cmd.clear_step) clr_q <= clr_q + AW'(1);
	end

	// key in hand and table selector
	assign ev = which_q ? rd2_q[KEY_W-1:0] : rd1_q[KEY_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) which_q <= 1'b0;
		else if (cmd.load_key) which_q <= 1'b0;
		else if (cmd.swap) which_q <= ~which_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_key) cur_q <= key;
		else if (cmd.swap) cur_q <= ev;
	end

	// table write ports
	always_comb begin
		we1 = cmd.clear_step || cmd.del1 || (cmd.wr_kick && !which_q);
		we2 = cmd.clear_step || cmd.del2 || (cmd.wr_kick && which_q);
		wa1 = cmd.clear_step ? clr_q : slot1_q;
		wa2 = cmd.clear_step ? clr_q : slot2_q;
		wd  = {cmd.wr_kick, cur_q};
	end

	always_ff @(posedge clk) begin
		if (we1) mem1[wa1] <= wd;
		if (we2) mem2[wa2] <= wd;
		if (cmd.rd_en) begin
			rd1_q <= mem1[slot1_q];
			rd2_q <= mem2[slot2_q];
		end
	end

	// stored count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cnt_q <= '0;
		else if (cmd.cnt_inc) cnt_q <= cnt_q + CNT_W'(1);
		else if (cmd.cnt_dec) cnt_q <= cnt_q - CNT_W'(1);
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ok_q   <= 1'b0;
			drop_q <= 1'b0;
			dkey_q <= '0;
		end else if (cmd.res_load) begin
			ok_q   <= cmd.res_ok;
			drop_q <= cmd.res_drop;
			dkey_q <= cmd.res_drop ? ev : '0;
		end
	end

	assign stat.clear_last = (clr_q == AW'(TABLE_DEPTH - 1));
	assign stat.div_done   = div_done;
	assign stat.hit1       = rd1_q[KEY_W] && (rd1_q[KEY_W-1:0] == cur_q);
	assign stat.hit2       = rd2_q[KEY_W] && (rd2_q[KEY_W-1:0] == cur_q);
	assign stat.sel_valid  = which_q ? rd2_q[KEY_W] : rd1_q[KEY_W];

	assign success       = ok_q;
	assign dropped_valid = drop_q;
	assign dropped_key   = dkey_q;
	assign entry_count   = cnt_q;

endmodule

FILE: design/cht_ctrl.sv
`timescale 1ns / 1ps

module cht_ctrl #(
	parameter int MAX_KICKS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         command,
	output logic               out_valid,
	input  logic               out_ready,
	input  cht_pkg::dp_stat_t  stat,
	output cht_pkg::dp_cmd_t   cmd
);
	import cht_pkg::*;

	localparam int KW = $clog2(MAX_KICKS + 1);

	state_t        state_q, state_d;
	cmd_t          op_q;
	logic          kick_mode_q, kick_mode_d;
	logic [KW-1:0] kick_q, kick_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			op_q        <= CMD_NOP;
			kick_mode_q <= 1'b0;
			kick_q      <= '0;
		end else begin
			state_q     <= state_d;
			kick_mode_q <= kick_mode_d;
			kick_q      <= kick_d;
			if (in_valid && in_ready) op_q <= cmd_t'(command);
		end
	end

	always_comb begin
		state_d     = state_q;
		kick_mode_d = kick_mode_q;
		kick_d      = kick_q;
		cmd         = '0;
		in_ready    = 1'b0;
		out_valid   = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (stat.clear_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_key = 1'b1;
					kick_mode_d  = 1'b0;
					kick_d       = '0;
					state_d      = ST_DIV1;
				end
			end
			ST_DIV1: begin
				cmd.div_start = 1'b1;
				state_d       = ST_WAIT1;
			end
			ST_WAIT1: begin
				if (stat.div_done) begin
					cmd.latch_s1 = 1'b1;
					state_d      = ST_DIV2;
				end
			end
			ST_DIV2: begin
				cmd.div_start  = 1'b1;
				cmd.div_second = 1'b1;
				state_d        = ST_WAIT2;
			end
			ST_WAIT2: begin
				if (stat.div_done) begin
					cmd.latch_s2 = 1'b1;
					state_d      = ST_READ;
				end
			end
			ST_READ: begin
				cmd.rd_en = 1'b1;
				state_d   = ST_CHECK;
			end
			ST_CHECK: begin
				if (kick_mode_q) begin
					// eviction step: place key, or swap with occupant
					cmd.wr_kick = 1'b1;
					if (!stat.sel_valid) begin
						cmd.cnt_inc  = 1'b1;
						cmd.res_load = 1'b1;
						cmd.res_ok   = 1'b1;
						state_d      = ST_OUT;
					end else begin
						cmd.swap = 1'b1;
						kick_d   = kick_q + KW'(1);
						if (kick_q == KW'(MAX_KICKS - 1)) begin
							cmd.res_load = 1'b1;
							cmd.res_drop = 1'b1;
							state_d      = ST_OUT;
						end else begin
							state_d = ST_DIV1;
						end
					end
				end else begin
					unique case (op_q)
						CMD_LOOKUP: begin
							cmd.res_load = 1'b1;
							cmd.res_ok   = stat.hit1 || stat.hit2;
							state_d      = ST_OUT;
						end
						CMD_INSERT: begin
							if (stat.hit1 || stat.hit2) begin
								cmd.res_load = 1'b1;
								cmd.res_ok   = 1'b1;
								state_d      = ST_OUT;
							end else begin
								// read data still holds table one at slot one
								kick_mode_d = 1'b1;
							end
						end
						CMD_DELETE: begin
							cmd.res_load = 1'b1;
							cmd.res_ok   = stat.hit1 || stat.hit2;
							cmd.del1     = stat.hit1;
							cmd.del2     = !stat.hit1 && stat.hit2;
							cmd.cnt_dec  = stat.hit1 || stat.hit2;
							state_d      = ST_OUT;
						end
						CMD_NOP: begin
							cmd.res_load = 1'b1;
							state_d      = ST_OUT;
						end
						default: state_d = ST_OUT;
					endcase
				end
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

FILE: design/cuckoo_hash_table_top.sv
`timescale 1ns / 1ps

// Two-table cuckoo hash set of signed 32-bit keys. Each word is a lookup,
// insert, delete or no-op and yields one result word. Slots are |key| mod
// capacity and (|key| div capacity) mod capacity, found by one shared
// bit-serial divider. An insert that has to evict rehashes each evicted key
// in turn, at most MAX_KICKS - 1 of them. One command is in flight at a
// time. After reset a clearing pass invalidates every slot before the first
// command is accepted; capacity writes are taken at any time and must only
// be issued while idle.
module cuckoo_hash_table_top #(
	parameter int TABLE_DEPTH = 1024,
	parameter int MAX_KICKS   = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [cht_pkg::CAP_W-1:0]        cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [1:0]                       command,
	input  logic signed [cht_pkg::KEY_W-1:0] key,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             success,
	output logic                             dropped_valid,
	output logic signed [cht_pkg::KEY_W-1:0] dropped_key,
	output logic [cht_pkg::CNT_W-1:0]        entry_count
);
	import cht_pkg::*;

	dp_cmd_t  dcmd;
	dp_stat_t dstat;

	assign cfg_ready = 1'b1;

	cht_ctrl #(.MAX_KICKS(MAX_KICKS)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.command   (command),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (dstat),
		.cmd       (dcmd)
	);

	cht_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (dcmd),
		.stat          (dstat),
		.cfg_valid     (cfg_valid && cfg_ready),
		.cfg_data      (cfg_data),
		.key           (key),
		.success       (success),
		.dropped_valid (dropped_valid),
		.dropped_key   (dropped_key),
		.entry_count   (entry_count)
	);

`ifndef NO_ASSERTIONS
	a_ready_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input ready while a result is pending");

	a_no_fast_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !out_valid)
		else $error("result in the cycle after accept");

	a_drop_not_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && dropped_valid) |-> !success)
		else $error("dropped key reported with success");

	a_dkey_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !dropped_valid) |-> (dropped_key == '0))
		else $error("dropped key nonzero without a drop");
`endif

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import cht_pkg::*;

	localparam int DEPTH = 1024;
	localparam int KICKS = 32;
	localparam int WATCH_LIMIT = 30000;
	localparam int HOLD_CYCLES = 400;

	typedef struct {
		bit                 ok;
		bit                 drop;
		logic [KEY_W-1:0]   dkey;
		logic [CNT_W-1:0]   cnt;
	} outcome_t;

	typedef struct {
		cmd_t               cmd;
		logic [KEY_W-1:0]   k;
		bit                 typed;
		outcome_t           res;
	} row_t;

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [CAP_W-1:0]        cfg_data;
	logic                    in_valid;
	logic                    in_ready;
	logic [1:0]              command;
	logic signed [KEY_W-1:0] key;
	logic                    out_valid;
	logic                    out_ready;
	logic                    success;
	logic                    dropped_valid;
	logic signed [KEY_W-1:0] dropped_key;
	logic [CNT_W-1:0]        entry_count;

	// shadow copy of the hash set
	logic [KEY_W-1:0] t1_keys [DEPTH];
	bit               t1_vld  [DEPTH];
	logic [KEY_W-1:0] t2_keys [DEPTH];
	bit               t2_vld  [DEPTH];
	int unsigned      n_stored;
	int unsigned      cap_reg;

	outcome_t pending_q [$];
	int       errors;
	int       n_words;
	int       n_drops;
	int       n_hits;
	bit       quiet;
	bit       stall_go;
	bit       stall_done;
	int       watch;

	cuckoo_hash_table_top #(
		.TABLE_DEPTH(DEPTH),
		.MAX_KICKS  (KICKS)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.key          (key),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.success      (success),
		.dropped_valid(dropped_valid),
		.dropped_key  (dropped_key),
		.entry_count  (entry_count)
	);

	always #2 clk = ~clk;

	function automatic int unsigned eff_slots();
		if (cap_reg == 0) return 1;
		if (cap_reg > DEPTH) return DEPTH;
		return cap_reg;
	endfunction

	function automatic int unsigned home_slot(bit second, logic [KEY_W-1:0] k);
		int unsigned c;
		int unsigned m;
		c = eff_slots();
		m = k[KEY_W-1] ? 32'(-k) : k;
		return second ? (m / c) % c : m % c;
	endfunction

	function automatic bit is_stored(logic [KEY_W-1:0] k);
		int unsigned p1;
		int unsigned p2;
		p1 = home_slot(0, k);
		p2 = home_slot(1, k);
		return (t1_vld[p1] && t1_keys[p1] == k) || (t2_vld[p2] && t2_keys[p2] == k);
	endfunction

	// apply one command to the shadow set and return its result word
	function automatic outcome_t apply_cmd(cmd_t c, logic [KEY_W-1:0] k);
		outcome_t         r;
		logic [KEY_W-1:0] cur;
		logic [KEY_W-1:0] ev;
		int unsigned      p;
		int unsigned      p2;
		bit               side;
		r = '{0, 0, '0, '0};
		case (c)
			CMD_LOOKUP: r.ok = is_stored(k);
			CMD_INSERT: begin
				if (is_stored(k)) begin
					r.ok = 1;
				end else begin
					cur = k;
					side = 0;
					for (int n = 0; n < KICKS && !r.ok; n++) begin
						p = home_slot(side, cur);
						if (!side) begin
							if (!t1_vld[p]) begin
								t1_keys[p] = cur;
								t1_vld[p] = 1;
								r.ok = 1;
							end else begin
								ev = t1_keys[p];
								t1_keys[p] = cur;
								cur = ev;
							end
						end else begin
							if (!t2_vld[p]) begin
								t2_keys[p] = cur;
								t2_vld[p] = 1;
								r.ok = 1;
							end else begin
								ev = t2_keys[p];
								t2_keys[p] = cur;
								cur = ev;
							end
						end
						side = ~side;
					end
					if (r.ok) begin
						n_stored++;
					end else begin
						r.drop = 1;
						r.dkey = cur;
					end
				end
			end
			CMD_DELETE: begin
				p = home_slot(0, k);
				p2 = home_slot(1, k);
				if (t1_vld[p] && t1_keys[p] == k) begin
					t1_vld[p] = 0;
					n_stored--;
					r.ok = 1;
				end else if (t2_vld[p2] && t2_keys[p2] == k) begin
					t2_vld[p2] = 0;
					n_stored--;
					r.ok = 1;
				end
			end
			default: ;
		endcase
		r.cnt = n_stored[CNT_W-1:0];
		return r;
	endfunction

	// offer one command word; hold it until taken
	task automatic send_word(cmd_t c, logic [KEY_W-1:0] k, bit typed, outcome_t want);
		outcome_t r;
		in_valid <= 1'b1;
		command <= c;
		key <= k;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		r = apply_cmd(c, k);
		pending_q.push_back(typed ? want : r);
		n_words++;
		if (!quiet && !stall_go && $urandom_range(99) < 6) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(12, 1)) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
	endtask

	task automatic write_capacity(logic [CAP_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		cap_reg = v;
	endtask

	// receiver: random stalls, one long hold-off on request
	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_go && !stall_done) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				stall_done = 1;
			end
			out_ready <= quiet || $urandom_range(99) >= 6;
		end
	end

	// result checker
	always @(posedge clk) begin
		outcome_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_q.size() == 0) begin
				$display("%0t: result word with nothing expected", $time);
				errors++;
			end else begin
				e = pending_q.pop_front();
				if (success !== e.ok || dropped_valid !== e.drop
						|| dropped_key !== e.dkey || entry_count !== e.cnt) begin
					$display("%0t: mismatch exp ok=%0d drop=%0d dkey=%h cnt=%0d",
						$time, e.ok, e.drop, e.dkey, e.cnt);
					$display("%0t:          act ok=%0d drop=%0d dkey=%h cnt=%0d",
						$time, success, dropped_valid, dropped_key, entry_count);
					errors++;
				end
				if (e.drop) n_drops++;
				if (e.ok) n_hits++;
			end
		end
	end

	// watchdog on handshake activity
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			watch <= 0;
		end else if (watch >= WATCH_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			watch <= watch + 1;
		end
	end

	row_t directed [$];
	logic [KEY_W-1:0] key_pool [48];

	initial begin
		int            caps [6];
		int            lens [6];
		int unsigned   roll;
		cmd_t          c;
		logic [KEY_W-1:0] k;
		outcome_t      none;

		clk = 0;
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		command <= '0;
		key <= '0;
		errors = 0;
		n_words = 0;
		n_drops = 0;
		n_hits = 0;
		quiet = 0;
		stall_go = 0;
		stall_done = 0;
		watch = 0;
		none = '{0, 0, '0, '0};
		for (int i = 0; i < DEPTH; i++) begin
			t1_vld[i] = 0;
			t2_vld[i] = 0;
			t1_keys[i] = '0;
			t2_keys[i] = '0;
		end
		n_stored = 0;
		cap_reg = CAP_RESET;

		// directed rows, run at the reset capacity
		directed = '{
			'{CMD_LOOKUP, 32'h0000_0000, 1, '{0, 0, 32'h0, 12'd0}},
			'{CMD_INSERT, 32'h8000_0000, 1, '{1, 0, 32'h0, 12'd1}},
			'{CMD_LOOKUP, 32'h8000_0000, 1, '{1, 0, 32'h0, 12'd1}},
			'{CMD_INSERT, 32'h7FFF_FFFF, 1, '{1, 0, 32'h0, 12'd2}},
			'{CMD_INSERT, 32'hFFFF_FFFF, 1, '{1, 0, 32'h0, 12'd3}},
			'{CMD_INSERT, 32'h8000_0000, 1, '{1, 0, 32'h0, 12'd3}},
			'{CMD_NOP,    32'h1234_5678, 1, '{0, 0, 32'h0, 12'd3}},
			'{CMD_DELETE, 32'h0000_0005, 1, '{0, 0, 32'h0, 12'd3}},
			'{CMD_INSERT, 32'h0000_0001, 0, none},
			'{CMD_LOOKUP, 32'hFFFF_FFFF, 0, none},
			'{CMD_DELETE, 32'hFFFF_FFFF, 0, none},
			'{CMD_DELETE, 32'h7FFF_FFFF, 0, none},
			'{CMD_INSERT, 32'h0000_0400, 0, none},
			'{CMD_INSERT, 32'hFFFF_FC00, 0, none},
			'{CMD_LOOKUP, 32'h5555_5555, 0, none},
			'{CMD_INSERT, 32'hAAAA_AAAA, 0, none},
			'{CMD_DELETE, 32'h8000_0000, 0, none},
			'{CMD_NOP,    32'hFFFF_FFFF, 0, none},
			'{CMD_DELETE, 32'h0000_0001, 0, none}
		};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_word(directed[i].cmd, directed[i].k, directed[i].typed, directed[i].res);
		drain();

		// capacity settings: saturating, zero, one, small odd, medium, full
		caps = '{2047, 0, 1, 7, 37, 1024};
		lens = '{300, 120, 100, 250, 280, 280};
		for (int ph = 0; ph < 6; ph++) begin
			write_capacity(CAP_W'(caps[ph]));
			quiet = (ph == 5);
			foreach (key_pool[i]) begin
				key_pool[i] = $urandom();
				if (i < 8) key_pool[i] = $urandom_range(64);
				if (i == 8) key_pool[i] = 32'h8000_0000;
				if (i == 9) key_pool[i] = 32'h7FFF_FFFF;
			end
			for (int n = 0; n < lens[ph]; n++) begin
				if (ph == 4 && n == 20) stall_go = 1;
				if (stall_done) stall_go = 0;
				roll = $urandom_range(99);
				c = roll < 50 ? CMD_INSERT : roll < 75 ? CMD_LOOKUP
					: roll < 95 ? CMD_DELETE : CMD_NOP;
				k = $urandom_range(99) < 75 ? key_pool[$urandom_range(47)] : $urandom();
				send_word(c, k, 0, none);
			end
			drain();
		end

		repeat (200) @(posedge clk);
		$display("Covered %0d command words over six capacity settings incl. 0 and 2047,",
			n_words);
		$display("with %0d successful commands and %0d dropped keys.", n_hits, n_drops);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
